@@ rtl/core/hrpkd_pkg.sv @@
// Package with the word types, register indexes and keycodes of the HID page-key decoder.
`timescale 1ns / 1ps
`default_nettype none

package hrpkd_pkg;

  localparam int unsigned DeviceSlots    = 4;
  localparam int unsigned MaxReportBytes = 64;
  localparam int unsigned CountWidth     = $clog2(MaxReportBytes + 1);

  localparam logic [7:0] KeyPageUp      = 8'h4B;
  localparam logic [7:0] KeyPageDown    = 8'h4E;
  localparam logic [7:0] KeyConsBack    = 8'hE9;
  localparam logic [7:0] KeyConsFwd     = 8'hEA;
  localparam logic [7:0] KeyShortBack   = 8'h01;
  localparam logic [7:0] KeyShortFwd    = 8'h02;
  localparam logic [7:0] KeyFifthA      = 8'h07;
  localparam logic [7:0] KeyFifthB      = 8'h09;

  localparam logic [1:0] BtnNone        = 2'd0;
  localparam logic [1:0] BtnBack        = 2'd1;
  localparam logic [1:0] BtnForward     = 2'd2;

  localparam logic [15:0] GapResetMs    = 16'd150;
  localparam logic [5:0]  IndexReset    = 6'd2;

  typedef enum logic [2:0] {
    RegProfileValid     = 3'd0,
    RegProfileByteIndex = 3'd1,
    RegProfilePageUp    = 3'd2,
    RegProfilePageDown  = 3'd3,
    RegProfilePressBit  = 3'd4,
    RegInjectGapMs      = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]  device_slot;
    logic [7:0]  report_byte;
    logic        end_of_report;
    logic [31:0] time_ms;
  } in_word_t;

  typedef struct packed {
    logic [7:0] decoded_key;
    logic       press_edge;
    logic [1:0] page_button;
    logic       inject_now;
  } out_word_t;

endpackage

`default_nettype wire

@@ rtl/core/hid_report_page_key_decoder.sv @@
// Top level of the HID page-key decoder: byte capture, report decode and press edges.
//
//  Channel   Direction  Handshake                 Word
//  in        sink       in_valid_i / in_stall_o   in_word_i   (in_word_t)
//  out       source     out_valid_o / out_stall_i out_word_o  (out_word_t)
//  cfg       sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A byte accepted into the input register is decoded from there into the result
// register, from which its word leaves, and one byte is taken in every cycle while
// the result register is not stalled. The per-slot state and the capture registers
// are updated in the decode stage, so consecutive bytes never wait on each other.
// A word stalled in the result register holds back the decode stage, and the
// input register then raises in_stall_o. Reset initialises all but the data words.
`timescale 1ns / 1ps
`default_nettype none

module hid_report_page_key_decoder import hrpkd_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_word_t  in_word_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_word_t      out_word_o,
  input  wire logic      cfg_valid_i,
  output logic           cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  logic        prof_valid_q;
  logic [5:0]  prof_index_q;
  logic [7:0]  prof_up_q;
  logic [7:0]  prof_down_q;
  logic        prof_bit_q;
  logic [15:0] gap_q;

  logic     in_valid_q;
  in_word_t in_word_q;

  logic [CountWidth-1:0] count_q, count_d;
  logic [7:0] first_q, first_d;
  logic [7:0] third_q, third_d;
  logic [7:0] fifth_q, fifth_d;
  logic [7:0] prof_byte_q, prof_byte_d;
  logic        held_q [DeviceSlots];
  logic [31:0] last_inj_q [DeviceSlots];

  logic      out_valid_q;
  out_word_t out_word_q;

  logic      advance;
  logic      fire;
  logic      emit;
  logic      pressed;
  logic      edge_det;
  logic      do_inject;
  logic [7:0] key;
  logic [1:0] btn;
  logic [31:0] elapsed;
  logic [CountWidth-1:0] len;
  logic [1:0] slot;

  assign advance     = !out_valid_q || !out_stall_i;
  assign fire        = in_valid_q && advance;
  assign in_stall_o  = in_valid_q && !advance;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign slot        = in_word_q.device_slot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prof_valid_q <= 1'b0;
      prof_index_q <= IndexReset;
      prof_up_q    <= KeyPageUp;
      prof_down_q  <= KeyPageDown;
      prof_bit_q   <= 1'b0;
      gap_q        <= GapResetMs;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        RegProfileValid:     prof_valid_q <= cfg_data_i[0];
        RegProfileByteIndex: prof_index_q <= cfg_data_i[5:0];
        RegProfilePageUp:    prof_up_q    <= cfg_data_i[7:0];
        RegProfilePageDown:  prof_down_q  <= cfg_data_i[7:0];
        RegProfilePressBit:  prof_bit_q   <= cfg_data_i[0];
        RegInjectGapMs:      gap_q        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Capture of the current byte, seen by the decode of the same byte.
  always_comb begin
    count_d     = count_q;
    first_d     = first_q;
    third_d     = third_q;
    fifth_d     = fifth_q;
    prof_byte_d = prof_byte_q;
    if (count_q < CountWidth'(MaxReportBytes)) begin
      if (count_q == CountWidth'(0)) first_d = in_word_q.report_byte;
      if (count_q == CountWidth'(2)) third_d = in_word_q.report_byte;
      if (count_q == CountWidth'(4)) fifth_d = in_word_q.report_byte;
      if (count_q == CountWidth'(prof_index_q)) prof_byte_d = in_word_q.report_byte;
      count_d = count_q + CountWidth'(1);
    end
  end

  assign len  = count_d;
  assign emit = in_word_q.end_of_report && (len >= CountWidth'(2));

  always_comb begin
    key     = 8'd0;
    pressed = 1'b0;
    if (prof_valid_q) begin
      if (len >= CountWidth'(prof_index_q) + CountWidth'(1)) key = prof_byte_d;
      if (prof_bit_q) pressed = first_d[0];
      else pressed = (key != 8'd0);
    end else if (len == CountWidth'(3)) begin
      key = third_d;
      if (first_d == KeyShortBack || key == KeyPageUp) begin
        key     = KeyPageUp;
        pressed = 1'b1;
      end else if (first_d == KeyShortFwd || key == KeyPageDown) begin
        key     = KeyPageDown;
        pressed = 1'b1;
      end else begin
        pressed = (key != 8'd0);
      end
    end else if (len == CountWidth'(6)) begin
      if (first_d == KeyShortBack) begin
        key     = KeyPageUp;
        pressed = 1'b1;
      end else if (first_d == KeyShortFwd) begin
        key     = KeyPageDown;
        pressed = 1'b1;
      end
    end else if (len >= CountWidth'(5)) begin
      if (fifth_d inside {KeyFifthA, KeyFifthB}) begin
        key     = fifth_d;
        pressed = first_d[0];
      end else begin
        key     = third_d;
        pressed = (key != 8'd0);
      end
    end else begin
      key     = (len > CountWidth'(2)) ? third_d : 8'd0;
      pressed = (key != 8'd0);
    end
  end

  assign edge_det = pressed && !held_q[slot];
  assign elapsed  = in_word_q.time_ms - last_inj_q[slot];

  always_comb begin
    btn = BtnNone;
    if (edge_det) begin
      if (prof_valid_q) begin
        if (key == prof_up_q) btn = BtnBack;
        else if (key == prof_down_q) btn = BtnForward;
      end else if (key inside {KeyShortBack, KeyPageUp, KeyConsBack}) begin
        btn = BtnBack;
      end else if (key inside {KeyShortFwd, KeyPageDown, KeyConsFwd}) begin
        btn = BtnForward;
      end
    end
  end

  assign do_inject = (btn != BtnNone) && (elapsed >= {16'd0, gap_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_word_q <= in_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      first_q     <= '0;
      third_q     <= '0;
      fifth_q     <= '0;
      prof_byte_q <= '0;
      for (int i = 0; i < DeviceSlots; i++) begin
        held_q[i]     <= 1'b0;
        last_inj_q[i] <= '0;
      end
    end else if (fire) begin
      if (in_word_q.end_of_report) begin
        count_q     <= '0;
        first_q     <= '0;
        third_q     <= '0;
        fifth_q     <= '0;
        prof_byte_q <= '0;
      end else begin
        count_q     <= count_d;
        first_q     <= first_d;
        third_q     <= third_d;
        fifth_q     <= fifth_d;
        prof_byte_q <= prof_byte_d;
      end
      if (emit) begin
        held_q[slot] <= pressed;
        if (do_inject) last_inj_q[slot] <= in_word_q.time_ms;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= fire && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      out_word_q.decoded_key <= key;
      out_word_q.press_edge  <= edge_det;
      out_word_q.page_button <= btn;
      out_word_q.inject_now  <= do_inject;
    end
  end

endmodule

`default_nettype wire

@@ dv/page_key_checker.sv @@
`timescale 1ns / 1ps
// Checker that mirrors the HID page-key decoder and compares every result word with its prediction.
module page_key_checker import hrpkd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_word_t    in_word_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_word_t   out_word_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_cnt_o,
  output int          pending_o
);

  logic        use_profile;
  logic [5:0]  key_index;
  logic [7:0]  back_code;
  logic [7:0]  fwd_code;
  logic        press_bit;
  logic [15:0] min_gap_ms;
  logic [6:0]  byte_cnt;
  logic [7:0]  byte0;
  logic [7:0]  byte2;
  logic [7:0]  byte4;
  logic [7:0]  indexed_byte;
  logic        key_down [DeviceSlots];
  logic [31:0] last_sent_ms [DeviceSlots];
  out_word_t   expected_words [$];
  int          fails;

  always @(posedge clk_i or negedge rst_ni) begin : predict
    out_word_t   want;
    out_word_t   got;
    logic [7:0]  key;
    logic        pressed;
    logic [31:0] elapsed;
    logic [1:0]  slot;
    int unsigned len;
    if (!rst_ni) begin
      use_profile = 1'b0;
      key_index = IndexReset;
      back_code = KeyPageUp;
      fwd_code = KeyPageDown;
      press_bit = 1'b0;
      min_gap_ms = GapResetMs;
      byte_cnt = '0;
      byte0 = '0;
      byte2 = '0;
      byte4 = '0;
      indexed_byte = '0;
      for (int s = 0; s < DeviceSlots; s++) begin
        key_down[s] = 1'b0;
        last_sent_ms[s] = '0;
      end
      expected_words.delete();
      fails = 0;
      fail_cnt_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          RegProfileValid:     use_profile = cfg_data_i[0];
          RegProfileByteIndex: key_index = cfg_data_i[5:0];
          RegProfilePageUp:    back_code = cfg_data_i[7:0];
          RegProfilePageDown:  fwd_code = cfg_data_i[7:0];
          RegProfilePressBit:  press_bit = cfg_data_i[0];
          RegInjectGapMs:      min_gap_ms = cfg_data_i;
          default: ;
        endcase
      end

      // Results leave in the order of their reports, so the oldest word is popped first.
      if (out_valid_i && !out_stall_i) begin
        got = out_word_i;
        if (expected_words.size() == 0) begin
          $error("unexpected result word %h", got);
          fails++;
        end else begin
          want = expected_words.pop_front();
          if (got.decoded_key !== want.decoded_key) begin
            $error("decoded_key: expected %0d, actual %0d", want.decoded_key, got.decoded_key);
            fails++;
          end
          if (got.press_edge !== want.press_edge) begin
            $error("press_edge: expected %0d, actual %0d", want.press_edge, got.press_edge);
            fails++;
          end
          if (got.page_button !== want.page_button) begin
            $error("page_button: expected %0d, actual %0d", want.page_button, got.page_button);
            fails++;
          end
          if (got.inject_now !== want.inject_now) begin
            $error("inject_now: expected %0d, actual %0d", want.inject_now, got.inject_now);
            fails++;
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        if (byte_cnt < MaxReportBytes) begin
          case (byte_cnt)
            0: byte0 = in_word_i.report_byte;
            2: byte2 = in_word_i.report_byte;
            4: byte4 = in_word_i.report_byte;
            default: ;
          endcase
          if (byte_cnt == key_index) indexed_byte = in_word_i.report_byte;
          byte_cnt = byte_cnt + 1;
        end
        if (in_word_i.end_of_report) begin
          len = byte_cnt;
          slot = in_word_i.device_slot;
          if (len >= 2 && slot < DeviceSlots) begin
            key = 8'h00;
            pressed = 1'b0;
            if (use_profile) begin
              if (len >= key_index + 1) key = indexed_byte;
              pressed = press_bit ? byte0[0] : (key != 8'h00);
            end else if (len == 3) begin
              key = byte2;
              if (byte0 == KeyShortBack || key == KeyPageUp) begin
                key = KeyPageUp;
                pressed = 1'b1;
              end else if (byte0 == KeyShortFwd || key == KeyPageDown) begin
                key = KeyPageDown;
                pressed = 1'b1;
              end else begin
                pressed = key != 8'h00;
              end
            end else if (len == 6) begin
              if (byte0 == KeyShortBack) begin
                key = KeyPageUp;
                pressed = 1'b1;
              end else if (byte0 == KeyShortFwd) begin
                key = KeyPageDown;
                pressed = 1'b1;
              end
            end else if (len >= 5) begin
              if (byte4 == KeyFifthA || byte4 == KeyFifthB) begin
                key = byte4;
                pressed = byte0[0];
              end else begin
                key = byte2;
                pressed = key != 8'h00;
              end
            end else begin
              key = (len > 2) ? byte2 : 8'h00;
              pressed = key != 8'h00;
            end

            want = '0;
            want.decoded_key = key;
            if (!pressed) begin
              key_down[slot] = 1'b0;
            end else if (!key_down[slot]) begin
              key_down[slot] = 1'b1;
              want.press_edge = 1'b1;
              want.page_button = BtnNone;
              if (use_profile) begin
                if (key == back_code) want.page_button = BtnBack;
                else if (key == fwd_code) want.page_button = BtnForward;
              end else if (key == KeyShortBack || key == KeyPageUp || key == KeyConsBack) begin
                want.page_button = BtnBack;
              end else if (key == KeyShortFwd || key == KeyPageDown || key == KeyConsFwd) begin
                want.page_button = BtnForward;
              end
              elapsed = in_word_i.time_ms - last_sent_ms[slot];
              if (want.page_button != BtnNone && elapsed >= {16'h0000, min_gap_ms}) begin
                want.inject_now = 1'b1;
                last_sent_ms[slot] = in_word_i.time_ms;
              end
            end
            expected_words = {expected_words, want};
          end
          byte_cnt = '0;
          byte0 = '0;
          byte2 = '0;
          byte4 = '0;
          indexed_byte = '0;
        end
      end

      fail_cnt_o <= fails;
      pending_o <= expected_words.size();
    end
  end

endmodule

@@ dv/tb_hid_report_page_key_decoder.sv @@
`timescale 1ns / 1ps
// Testbench top for the HID page-key decoder: clock, reset, configuration, report stimulus, idling, stalls and verdict.
module tb_hid_report_page_key_decoder;
  import hrpkd_pkg::*;

  localparam int unsigned QuietLimit    = 3000;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned ItemsPerPhase = 156;
  localparam int unsigned Phases        = 8;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_word_t    in_word_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_word_t   out_word_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  int          fail_cnt;
  int          pending;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_asked = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  int          quiet_cycles = 0;
  int          phase_items = 0;
  logic [7:0]  rpt_bytes [80];
  logic [31:0] now_ms = '0;
  logic [1:0]  last_slot = '0;
  logic [7:0]  back_code = KeyPageUp;
  logic [7:0]  fwd_code = KeyPageDown;

  hid_report_page_key_decoder DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  page_key_checker u_page_key_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_i  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      out_stall_i <= 1'b1;
      hold_served <= hold_served + 1;
      hold_left <= HoldCycles;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == QuietLimit) begin
        $display("hid_report_page_key_decoder test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    phase_items++;
  endtask

  task automatic send_report(input int len, input logic [1:0] slot, input logic [31:0] stamp);
    in_word_t w;
    for (int i = 0; i < len; i++) begin
      w.device_slot = (i == len - 1) ? slot : $urandom_range(3);
      w.report_byte = rpt_bytes[i];
      w.end_of_report = (i == len - 1);
      w.time_ms = (i == len - 1) ? stamp : $urandom;
      send_word(w);
    end
  endtask

  task automatic directed(input int len, input logic [1:0] slot, input logic [31:0] stamp,
                          input logic [39:0] bytes);
    for (int i = 0; i < len; i++) rpt_bytes[i] = bytes[39 - 8 * i -: 8];
    send_report(len, slot, stamp);
  endtask

  task automatic random_report;
    int         len;
    int         r;
    logic [1:0] slot;
    logic       blank;
    r = $urandom_range(99);
    if (r < 5) len = 1;
    else if (r < 10) len = 2;
    else if (r < 35) len = 3;
    else if (r < 50) len = 4;
    else if (r < 60) len = 5;
    else if (r < 78) len = 6;
    else if (r < 90) len = $urandom_range(12, 7);
    else if (r < 97) len = $urandom_range(40, 13);
    else len = $urandom_range(70, 60);
    slot = ($urandom_range(1) != 0) ? last_slot : $urandom_range(3);
    last_slot = slot;
    // All-zero reports of two bytes or more release the held key on their slot.
    blank = $urandom_range(99) < 20;
    for (int i = 0; i < len; i++) begin
      if (blank) begin
        rpt_bytes[i] = 8'h00;
      end else begin
        case ($urandom_range(15))
          0: rpt_bytes[i] = 8'h00;
          1: rpt_bytes[i] = KeyShortBack;
          2: rpt_bytes[i] = KeyShortFwd;
          3: rpt_bytes[i] = KeyFifthA;
          4: rpt_bytes[i] = KeyFifthB;
          5: rpt_bytes[i] = KeyPageUp;
          6: rpt_bytes[i] = KeyPageDown;
          7: rpt_bytes[i] = KeyConsBack;
          8: rpt_bytes[i] = KeyConsFwd;
          9: rpt_bytes[i] = back_code;
          10: rpt_bytes[i] = fwd_code;
          default: rpt_bytes[i] = $urandom_range(255);
        endcase
      end
    end
    r = $urandom_range(99);
    if (r < 4) now_ms = $urandom;
    else if (r < 7) now_ms = 32'hFFFF_FF00 | $urandom_range(255);
    else now_ms = now_ms + $urandom_range(300);
    send_report(len, slot, now_ms);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic configure(input logic pv, input logic [5:0] idx, input logic [7:0] up,
                           input logic [7:0] dn, input logic pb, input logic [15:0] gap);
    logic [15:0] junk;
    junk = $urandom;
    write_reg(RegProfileValid, {junk[15:1], pv});
    write_reg(RegProfileByteIndex, {junk[15:6], idx});
    write_reg(RegProfilePageUp, {junk[15:8], up});
    write_reg(RegProfilePageDown, {junk[7:0], dn});
    write_reg(RegProfilePressBit, {junk[14:0], pb});
    write_reg(RegInjectGapMs, gap);
    cfg_valid_i <= 1'b0;
    back_code = up;
    fwd_code = dn;
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    logic [15:0] gap;
    int          pick;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed(1, 0, 32'd10, {KeyShortBack, 32'h0});
    directed(3, 0, 32'd1000, {KeyShortBack, 32'h0});
    directed(3, 0, 32'd1010, 40'h0);
    directed(3, 0, 32'd1050, {16'h0, KeyPageDown, 16'h0});
    directed(4, 2, 32'd2000, {16'h0, KeyConsBack, 8'hFF, 8'h00});
    directed(5, 3, 32'd3000, {8'h01, 8'h00, 8'h33, 8'h00, KeyFifthA});
    directed(3, 1, 32'hFFFF_FF80, {KeyShortFwd, 32'h0});
    directed(2, 1, 32'hFFFF_FFC0, 40'h0);
    directed(3, 1, 32'h0000_0010, {KeyShortBack, 32'h0});
    drain;

    for (int ph = 0; ph < Phases; ph++) begin
      case (ph)
        0: configure(1'b0, IndexReset, KeyPageUp, KeyPageDown, 1'b0, GapResetMs);
        1: configure(1'b1, 6'd0, 8'h00, 8'hFF, 1'b0, 16'h0000);
        2: configure(1'b1, 6'd63, 8'hFF, 8'h00, 1'b1, 16'hFFFF);
        3: configure(1'b0, 6'd63, 8'hFF, 8'hFF, 1'b1, 16'h0000);
        default: begin
          pick = $urandom_range(3);
          if (pick == 0) gap = 16'h0000;
          else if (pick == 1) gap = 16'hFFFF;
          else gap = $urandom_range(400, 1);
          configure($urandom_range(1),
                    ($urandom_range(3) == 0) ? 6'd63 : $urandom_range(8),
                    ($urandom_range(1) != 0) ? KeyPageUp : $urandom_range(255),
                    ($urandom_range(1) != 0) ? KeyPageDown : $urandom_range(255),
                    $urandom_range(1), gap);
        end
      endcase
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct = 73;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct <= 73;
        end
        default: begin
          send_idle_pct = 15;
          recv_stall_pct <= 15;
        end
      endcase
      phase_items = 0;
      // The receiver holds off for a long stretch while words keep coming.
      if (ph == 0) begin
        repeat (5) random_report;
        hold_asked <= hold_asked + 1;
      end
      while (phase_items < ItemsPerPhase) random_report;
      drain;
    end

    if (fail_cnt == 0 && pending == 0) begin
      $display("hid_report_page_key_decoder test passed");
    end else begin
      $display("hid_report_page_key_decoder test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/hrpkd_pkg.sv
rtl/core/hid_report_page_key_decoder.sv
dv/page_key_checker.sv
dv/tb_hid_report_page_key_decoder.sv
